// ===== rtl/mbcrc_pkg.sv =====
package mbcrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] LOW_MASK = 16'h00FF;
  localparam logic [2:0]  IDX_MAX  = 3'd7;
  localparam logic [2:0]  IDX_HUM_HI = 3'd2;
  localparam logic [2:0]  IDX_HUM_LO = 3'd3;

  typedef struct packed {
    logic        crc_ok;
    logic        short_frame;
    logic [15:0] computed_crc;
    logic [15:0] humidity_tenths;
  } res_t;

  // one byte folded into the reflected crc, eight shift steps
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbcrc_core.sv =====
module mbcrc_core
  import mbcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output res_t       res
);

  logic [15:0] running_crc;
  logic [7:0]  delay0;
  logic [7:0]  delay1;
  logic [2:0]  byte_index;
  logic [15:0] humidity_word;

  logic [15:0] running_crc_next;
  logic [15:0] humidity_word_next;
  logic [2:0]  byte_index_next;

  always_comb begin
    running_crc_next = running_crc;
    if (byte_index >= IDX_HUM_HI) begin
      running_crc_next = crc_fold(running_crc, delay0);
    end
    humidity_word_next = humidity_word;
    if (byte_index == IDX_HUM_HI) begin
      humidity_word_next = {data_byte, humidity_word[7:0]};
    end else if (byte_index == IDX_HUM_LO) begin
      humidity_word_next = {humidity_word[15:8], data_byte};
    end
    byte_index_next = (byte_index == IDX_MAX) ? byte_index : byte_index + 3'd1;

    res.short_frame     = (byte_index == 3'd0);
    res.crc_ok          = (byte_index != 3'd0) && (data_byte == running_crc_next[15:8])
                          && (delay1 == running_crc_next[7:0]);
    res.computed_crc    = running_crc_next;
    res.humidity_tenths = humidity_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      running_crc   <= CRC_INIT;
      delay0        <= 8'h00;
      delay1        <= 8'h00;
      byte_index    <= 3'd0;
      humidity_word <= 16'h0000;
    end else if (step) begin
      running_crc   <= running_crc_next;
      delay0        <= delay1;
      delay1        <= data_byte;
      byte_index    <= byte_index_next;
      humidity_word <= humidity_word_next;
    end
  end

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> byte_index == 3'd0 && running_crc == CRC_INIT
                          && humidity_word == 16'h0000)
    else $error("state not cleared after final beat");

  a_index_counts: assert property (@(posedge clk) disable iff (rst)
    step && !last_byte && byte_index != IDX_MAX |=> byte_index == $past(byte_index) + 3'd1)
    else $error("byte index did not advance");

  a_crc_idle_early: assert property (@(posedge clk) disable iff (rst)
    byte_index < IDX_HUM_HI |-> running_crc == CRC_INIT)
    else $error("crc changed before third byte");

  a_short_fails: assert property (@(posedge clk) disable iff (rst)
    res.short_frame |-> !res.crc_ok && res.computed_crc == CRC_INIT
                        && res.humidity_tenths == 16'h0000)
    else $error("short frame result malformed");

endmodule

// ===== rtl/modbus_crc_frame_checker_unit.sv =====
// a final beat's result passes the input register, then the state update
// and result register; a stall on the output can hold it between them
// throughput: one byte per cycle when not stalled; the crc fold is eight combinational shift steps
// input side stalls only while a final byte waits for a full, stalled result register
// reset (rst, synchronous, active high) clears valids, crc to 0xffff and frame state
module modbus_crc_frame_checker_unit
  import mbcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // computed_crc, humidity_tenths
  output logic [1:0]  m_axis_tuser   // crc_ok, short_frame
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_free;
  logic       adv;
  res_t       res;
  res_t       out_res;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign adv           = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  mbcrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .data_byte (in_byte),
    .last_byte (in_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= adv && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {out_res.humidity_tenths, out_res.computed_crc};
  assign m_axis_tuser = {out_res.short_frame, out_res.crc_ok};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !(adv && in_last))
    else $error("pending result overwritten");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(adv) && $past(in_last))
    else $error("result without final beat");

  a_nonfinal_flows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_last |-> s_axis_tready)
    else $error("stall on non-final beat");

endmodule
